>>> design/qda_pkg.sv
// Package for the quadrature decoder angle core.
// Holds the beat types, action codes and fixed widths shared by all modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qda_pkg;

    // Fixed field widths.
    localparam int POS_W               = 32;
    localparam int ANGLE_W             = 9;
    localparam int CPR_W               = 10;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    // Scale and reset value of the divisor register.
    localparam int          DEGREES_PER_REV = 360;
    localparam logic [CPR_W-1:0] CPR_RESET  = CPR_W'(98);

    // Action codes of an input beat.
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Encoder line pairs, packed as {B, A}.
    localparam logic [1:0] LINES_IDLE   = 2'b00;
    localparam logic [1:0] LINES_A_HIGH = 2'b01;
    localparam logic [1:0] LINES_B_HIGH = 2'b10;

    typedef struct packed {
        logic [1:0] action;
        logic       line_a;
        logic       line_b;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_count;
        logic [ANGLE_W-1:0]      angle_degrees;
    } out_item_t;

    // Status of the angle unit toward the top level.
    typedef struct packed {
        logic               valid;
        logic [ANGLE_W-1:0] angle;
    } qda_div_res_t;

endpackage

`default_nettype wire

>>> design/qda_counter.sv
// Line pair and position count state of the quadrature decoder.
// Updates on each accepted input beat. Uses qda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qda_counter
    import qda_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire in_item_t                      item,
    output logic signed [COUNT_WIDTH-1:0]      count
);

    logic [1:0]             lines;
    logic [1:0]             prev_lines_reg;
    logic [1:0]             prev_lines_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    assign lines = {item.line_b, item.line_a};

    // Decode the action and the move from the stored pair to the new one.
    always_comb
    begin
        prev_lines_next = prev_lines_reg;
        count_next      = count_reg;
        case (item.action)
            ACT_SAMPLE:
            begin
                if (lines == LINES_IDLE)
                begin
                    if (prev_lines_reg == LINES_B_HIGH)
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                    else if (prev_lines_reg == LINES_A_HIGH)
                    begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
                prev_lines_next = lines;
            end
            ACT_LOAD:
            begin
                prev_lines_next = lines;
            end
            ACT_CLEAR:
            begin
                prev_lines_next = LINES_IDLE;
                count_next      = '0;
            end
            default:
            begin
                prev_lines_next = prev_lines_reg;
                count_next      = count_reg;
            end
        endcase
    end

    // State registers, written only when a beat is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lines_reg <= LINES_IDLE;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            prev_lines_reg <= prev_lines_next;
            count_reg      <= count_next;
        end
    end

    assign count = signed'(count_reg);

endmodule

`default_nettype wire

>>> design/qda_divider.sv
// Bit-serial angle unit: scales the count magnitude by 360, divides it by the
// counts per revolution one quotient bit per cycle and reduces each quotient
// bit into a running remainder modulo 360. Uses qda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qda_divider
    import qda_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [COUNT_WIDTH-1:0] count,
    input  wire logic [CPR_W-1:0]              cpr,
    input  wire logic                          take,
    output qda_div_res_t                       res
);

    localparam int PROD_W = COUNT_WIDTH + 9;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam logic [ANGLE_W:0] DEG_EXT = (ANGLE_W+1)'(DEGREES_PER_REV);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_HOLD
    } state_t;

    state_t             state_reg;
    logic [PROD_W-1:0]  div_reg;
    logic [CPR_W-1:0]   rem_reg;
    logic [ANGLE_W-1:0] mod_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [ANGLE_W-1:0] angle_reg;

    logic [COUNT_WIDTH-1:0] mag;
    logic [PROD_W-1:0]      product;
    logic [CPR_W:0]         rem_shift;
    logic [CPR_W:0]         rem_diff;
    logic                   qbit;
    logic [CPR_W-1:0]       rem_next;
    logic [ANGLE_W:0]       mod_shift;
    logic [ANGLE_W-1:0]     mod_next;
    logic [ANGLE_W-1:0]     angle_next;

    // Magnitude of the count and its exact product with 360.
    assign mag     = count[COUNT_WIDTH-1] ? (-count) : count;
    assign product = PROD_W'(mag) * PROD_W'(DEGREES_PER_REV);

    // One restoring division step per cycle.
    assign rem_shift = {rem_reg, div_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, cpr};
    assign qbit      = (rem_shift >= {1'b0, cpr});
    assign rem_next  = qbit ? rem_diff[CPR_W-1:0] : rem_shift[CPR_W-1:0];

    // Fold the new quotient bit into the remainder modulo 360.
    assign mod_shift = {mod_reg, qbit};
    assign mod_next  = (mod_shift >= DEG_EXT) ? ANGLE_W'(mod_shift - DEG_EXT)
                                              : mod_shift[ANGLE_W-1:0];

    // Zero divisor gives 0; a negative quotient wraps back into the upper part of the circle.
    always_comb
    begin
        if (cpr == '0)
        begin
            angle_next = '0;
        end
        else if (neg_reg && (mod_reg != '0))
        begin
            angle_next = ANGLE_W'(DEG_EXT - {1'b0, mod_reg});
        end
        else
        begin
            angle_next = mod_reg;
        end
    end

    // Sequencer registers: state and bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= CNT_W'(PROD_W - 1);
                    end
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Shift registers of the dividend, partial remainder and angle remainder, plus sign and angle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            div_reg <= product;
            rem_reg <= '0;
            mod_reg <= '0;
            neg_reg <= count[COUNT_WIDTH-1];
        end
        else if (state_reg == ST_RUN)
        begin
            div_reg <= {div_reg[PROD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            mod_reg <= mod_next;
        end
        if (state_reg == ST_FIN)
        begin
            angle_reg <= angle_next;
        end
    end

    assign res.valid = (state_reg == ST_HOLD);
    assign res.angle = angle_reg;

endmodule

`default_nettype wire

>>> design/quadrature_decoder_angle_core.sv
// A beat is registered as a divider start; the divider then works out one
// quotient bit per cycle, and a finish state stores the angle for the output.
// A new beat is taken only after the output register takes the last result;
// a finished result waits in the output register while the next beat is taken.
// Reset (rst_n, asynchronous, active low) clears the count and the line pair
// and sets counts per revolution to 98.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_decoder_angle_core
    import qda_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire in_item_t         item_data,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output out_item_t             result_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CPR_W-1:0] cfg_data
);

    logic                          busy_reg;
    logic                          start_reg;
    logic [CPR_W-1:0]              cpr_reg;
    logic                          out_valid_reg;
    out_item_t                     out_data_reg;
    logic                          item_accept;
    logic                          res_take;
    logic signed [COUNT_WIDTH-1:0] count;
    qda_div_res_t                  div_res;

    assign item_ready  = ~busy_reg;
    assign item_accept = item_valid & item_ready;
    assign cfg_ready   = 1'b1;
    assign res_take    = div_res.valid & (~out_valid_reg | result_ready);

    qda_counter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_counter (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (item_accept),
        .item   (item_data),
        .count  (count)
    );

    qda_divider #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .count  (count),
        .cpr    (cpr_reg),
        .take   (res_take),
        .res    (div_res)
    );

    // Divisor register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cpr_reg <= cfg_data;
        end
    end

    // Busy flag and divider start, one beat in flight at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= item_accept;
            if (item_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (res_take)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, captured with the finished angle.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg.position_count <= POS_W'(count);
            out_data_reg.angle_degrees  <= div_res.angle;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

`default_nettype wire

>>> design/qda_checker.sv
// Port-level checks for the quadrature decoder angle core, with its bind.
// Depends on qda_pkg and quadrature_decoder_angle_core.
`timescale 1ns / 1ps
`default_nettype none

module qda_checker
    import qda_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire out_item_t        result_data
);

    // An accepted beat occupies the block until its result moves out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken again right after a beat was accepted");

    // A new result appears exactly when the block frees its input.
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> item_ready)
        else $error("result appeared while the input was still held");

    // The angle stays within one revolution.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.angle_degrees < ANGLE_W'(DEGREES_PER_REV)))
        else $error("angle out of range");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

endmodule

bind quadrature_decoder_angle_core qda_checker u_qda_checker (.*);

`default_nettype wire
